### hw/rtl/oai_pkg.sv
// Shared types and constants for the ordered array insert/delete core.
package oai_pkg;

  // Fixed field widths of the request and result items
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned CAP_W    = 5;

  // Packed stream widths (whole bytes)
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  // Capacity value after reset
  localparam int unsigned CAP_RESET = 16;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 3'd0,
    FUNC_INSERT = 3'd1,
    FUNC_EDIT   = 3'd2,
    FUNC_DELETE = 3'd3,
    FUNC_READ   = 3'd4
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted request
    logic exec;  // apply the captured request and load the result register
  } dp_cmd_t;

endpackage

### hw/rtl/oai_ctrl.sv
// Controller state machine: request handshake, sequencing and result valid.
module oai_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output oai_pkg::dp_cmd_t  cmd_o
);

  oai_pkg::fsm_e state_q, state_d;
  logic          out_valid_q, out_valid_d;

  // State and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oai_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      oai_pkg::S_IDLE: begin
        // take a request only if the result register is free by the next cycle
        req_ready_o = !out_valid_q || rsp_ready_i;
        if (req_valid_i && req_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = oai_pkg::S_EXEC;
        end
      end
      oai_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = oai_pkg::S_IDLE;
      end
      default: state_d = oai_pkg::S_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

### hw/rtl/oai_dpath.sv
// Datapath: entry register row with per-cell shift muxes, count, capacity, result.
module oai_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  oai_pkg::dp_cmd_t                cmd_i,
  input  logic [oai_pkg::FUNC_W-1:0]      func_i,
  input  logic [oai_pkg::INDEX_W-1:0]     index_i,
  input  logic [oai_pkg::DATA_W-1:0]      data_i,
  input  logic                            cfg_we_i,
  input  logic [oai_pkg::CAP_W-1:0]       cfg_wdata_i,
  output logic [oai_pkg::DATA_W-1:0]      read_data_o,
  output logic [oai_pkg::STATUS_W-1:0]    status_o,
  output logic [oai_pkg::LEVEL_W-1:0]     fill_level_o,
  output logic                            is_full_o,
  output logic                            is_empty_o
);

  // Count width holds 0..DEPTH; compare width covers count and request index
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > oai_pkg::INDEX_W) ? CW : oai_pkg::INDEX_W;
  localparam int unsigned CAP_INIT = (oai_pkg::CAP_RESET < DEPTH) ?
                                     oai_pkg::CAP_RESET : DEPTH;

  // Captured request
  oai_pkg::func_e               func_q;
  logic [oai_pkg::INDEX_W-1:0]  idx_q;
  logic [oai_pkg::DATA_W-1:0]   data_q;

  // Array state
  logic [oai_pkg::DATA_W-1:0]   entries_q [DEPTH];
  logic [oai_pkg::DATA_W-1:0]   entries_d [DEPTH];
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                cap_q, cap_d;

  // Result register
  logic [oai_pkg::DATA_W-1:0]   rd_q, rd_d;
  oai_pkg::status_e             status_q, status_d;
  logic [CW-1:0]                level_q;
  logic                         full_flag_q, full_flag_d;
  logic                         empty_flag_q, empty_flag_d;

  logic [XW-1:0]                idx_x;
  logic [XW-1:0]                cnt_x;
  logic [XW-1:0]                cfg_x;
  logic                         full;
  logic                         idx_lt_cnt;
  logic                         idx_le_cnt;
  logic                         ins_ok;
  logic                         del_ok;
  logic                         edit_ok;
  logic                         app_ok;
  logic [oai_pkg::DATA_W-1:0]   sel_data;

  assign idx_x      = XW'(idx_q);
  assign cnt_x      = XW'(count_q);
  assign cfg_x      = XW'(cfg_wdata_i);
  assign full       = count_q >= cap_q;
  assign idx_lt_cnt = idx_x < cnt_x;
  assign idx_le_cnt = idx_x <= cnt_x;

  assign app_ok  = (func_q == oai_pkg::FUNC_APPEND) && !full;
  assign ins_ok  = (func_q == oai_pkg::FUNC_INSERT) && !full && idx_le_cnt;
  assign edit_ok = (func_q == oai_pkg::FUNC_EDIT)   && idx_lt_cnt;
  assign del_ok  = (func_q == oai_pkg::FUNC_DELETE) && idx_lt_cnt;

  // Capture the accepted request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= oai_pkg::func_e'(func_i);
      idx_q  <= index_i;
      data_q <= data_i;
    end
  end

  // Select the entry at the request index
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (idx_x == XW'(i)) begin
        sel_data = entries_q[i];
      end
    end
  end

  // Per-cell next value: write, shift up on insert, shift down on delete
  always_comb begin
    entries_d = entries_q;
    if (cmd_i.exec) begin
      for (int i = 1; i < DEPTH; i++) begin
        if (ins_ok && (XW'(i) > idx_x) && (XW'(i) <= cnt_x)) begin
          entries_d[i] = entries_q[i-1];
        end
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (del_ok && (XW'(i) >= idx_x) && (XW'(i + 1) < cnt_x)) begin
          entries_d[i] = entries_q[i+1];
        end
      end
      for (int i = 0; i < DEPTH; i++) begin
        if ((app_ok && (XW'(i) == cnt_x)) ||
            ((ins_ok || edit_ok) && (XW'(i) == idx_x))) begin
          entries_d[i] = data_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
  end

  // Count, capacity and result values
  always_comb begin
    count_d  = count_q;
    cap_d    = cap_q;
    rd_d     = '0;
    status_d = oai_pkg::ST_OK;
    case (func_q)
      oai_pkg::FUNC_APPEND: begin
        if (full) begin
          status_d = oai_pkg::ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      oai_pkg::FUNC_INSERT: begin
        if (full) begin
          status_d = oai_pkg::ST_FULL;
        end else if (!idx_le_cnt) begin
          status_d = oai_pkg::ST_BADIDX;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      oai_pkg::FUNC_EDIT: begin
        if (!idx_lt_cnt) begin
          status_d = oai_pkg::ST_BADIDX;
        end
      end
      oai_pkg::FUNC_DELETE: begin
        if (!idx_lt_cnt) begin
          status_d = oai_pkg::ST_BADIDX;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      oai_pkg::FUNC_READ: begin
        if (!idx_lt_cnt) begin
          status_d = oai_pkg::ST_BADIDX;
        end else begin
          rd_d = sel_data;
        end
      end
      default: ;
    endcase
    full_flag_d  = count_d == cap_q;
    empty_flag_d = count_d == '0;
    if (!cmd_i.exec) begin
      count_d = count_q;
    end
    // Capacity write clamps to 1..DEPTH and empties the array
    if (cfg_we_i) begin
      count_d = '0;
      if (cfg_x == '0) begin
        cap_d = CW'(1);
      end else if (cfg_x > XW'(DEPTH)) begin
        cap_d = CW'(DEPTH);
      end else begin
        cap_d = CW'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CW'(CAP_INIT);
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q         <= rd_d;
      status_q     <= status_d;
      level_q      <= count_d;
      full_flag_q  <= full_flag_d;
      empty_flag_q <= empty_flag_d;
    end
  end

  assign read_data_o  = rd_q;
  assign status_o     = status_q;
  assign fill_level_o = oai_pkg::LEVEL_W'(level_q);
  assign is_full_o    = full_flag_q;
  assign is_empty_o   = empty_flag_q;

endmodule

### hw/rtl/ordered_array_insert_delete_core.sv
// Top level of the ordered array insert/delete core.
// Keeps an ordered list of signed 32-bit words in a row of DEPTH registers and
// applies one request at a time: append, insert at an index (later entries
// move up), edit, delete at an index (later entries move down) or read. Each
// request gives one result with read data, status, fill level and full/empty
// flags. A request is first captured, and then every cell of the register row
// picks its next value in parallel; no new request is taken while one is being
// applied. The result sits in an output register, and the next request can be
// taken no earlier than the cycle in which the result is taken. Writing the
// capacity register (clamped to 1..DEPTH) empties the list; write it only while
// no request is in flight.
module ordered_array_insert_delete_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request: func [2:0], index [7:3], data [39:8]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [oai_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // result: read_data [31:0], status [33:32], fill_level [38:34],
  //         is_full [39], is_empty [40], zero [47:41]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [oai_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // capacity register
  input  logic                                cfg_we_i,
  input  logic [oai_pkg::CAP_W-1:0]           cfg_wdata_i
);

  oai_pkg::dp_cmd_t                 cmd;
  logic [oai_pkg::DATA_W-1:0]       read_data;
  logic [oai_pkg::STATUS_W-1:0]     status;
  logic [oai_pkg::LEVEL_W-1:0]      fill_level;
  logic                             is_full;
  logic                             is_empty;

  // Sequence requests and results
  oai_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Hold the array and compute results
  oai_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (s_axis_tdata[2:0]),
    .index_i      (s_axis_tdata[7:3]),
    .data_i       (s_axis_tdata[39:8]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .read_data_o  (read_data),
    .status_o     (status),
    .fill_level_o (fill_level),
    .is_full_o    (is_full),
    .is_empty_o   (is_empty)
  );

  // Pack the result
  assign m_axis_tdata = {7'd0, is_empty, is_full, fill_level, status, read_data};

endmodule
